// ----- design/ikin_pkg.sv -----
// ----------------------------------------------------------------------------
// ikin_pkg: shared types and constants
// Fixed-point widths, link length reset value, register indexes and the
// arctangent table used by the two-link inverse kinematics core.
// ----------------------------------------------------------------------------
package ikin_pkg;

   localparam int COORD_WIDTH       = 16;
   localparam int ANGLE_WIDTH_DEF   = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam int MAG_W     = COORD_WIDTH;
   localparam int SQ_W      = 2 * COORD_WIDTH;
   localparam int L3_W      = COORD_WIDTH + 8;
   localparam int ROOT_IN_W = 2 * L3_W;
   localparam int LEN_W     = 16;
   localparam int LP_W      = 2 * LEN_W;
   localparam int SUM_W     = LP_W + 1;
   localparam int PROD_A_W  = L3_W + LEN_W;
   localparam int DIV_A_W   = SUM_W + 9;
   localparam int DIV_B_W   = L3_W + 1;
   localparam int DIV_C_W   = SUM_W + 1;
   localparam int Q30_W     = 31;
   localparam int TRIG_W    = 2 * Q30_W;
   localparam int XY_W      = Q30_W + 3;
   localparam int Z_W       = Q30_W + 2;
   localparam int ANG_W     = Q30_W + 5;
   localparam int IN_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;

   localparam logic [LEN_W-1:0]  LEN_RESET   = 16'd2022;
   localparam logic [Q30_W-1:0]  Q30_ONE     = 31'h4000_0000;
   localparam logic [31:0]       PI_Q30      = 32'd3373259426;
   localparam logic [Z_W-1:0]    HALF_PI_Q30 = 33'd1686629713;

   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] REG_UPPER_LEN = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_LOWER_LEN = 1'b1;

   typedef struct packed {
      logic [SQ_W-1:0]  l3s;
      logic [MAG_W-1:0] ay;
      logic             yneg;
   } root_side_type;

   function automatic logic [Q30_W-1:0] atan_q30(input int unsigned idx);
      logic [Q30_W-1:0] v;
      case (idx)
         0:  v = 31'h3243F6A8;
         1:  v = 31'h1DAC6705;
         2:  v = 31'h0FADBAFC;
         3:  v = 31'h07F56EA6;
         4:  v = 31'h03FEAB76;
         5:  v = 31'h01FFD55B;
         6:  v = 31'h00FFFAAA;
         7:  v = 31'h007FFF55;
         8:  v = 31'h003FFFEA;
         9:  v = 31'h001FFFFD;
         10: v = 31'h000FFFFF;
         11: v = 31'h0007FFFF;
         12: v = 31'h0003FFFF;
         13: v = 31'h0001FFFF;
         14: v = 31'h0000FFFF;
         15: v = 31'h00007FFF;
         16: v = 31'h00003FFF;
         17: v = 31'h00001FFF;
         18: v = 31'h00000FFF;
         19: v = 31'h000007FF;
         20: v = 31'h000003FF;
         21: v = 31'h000001FF;
         22: v = 31'h000000FF;
         23: v = 31'h0000007F;
         24: v = 31'h0000003F;
         25: v = 31'h0000001F;
         26: v = 31'h0000000F;
         27: v = 31'h00000008;
         28: v = 31'h00000004;
         29: v = 31'h00000002;
         30: v = 31'h00000001;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- design/ikin_sqrt.sv -----
// ----------------------------------------------------------------------------
// ikin_sqrt: pipelined integer square root
// One cell per result bit; each cell does one trial subtract and hands the
// remainder and partial root to the next cell.
// ----------------------------------------------------------------------------
module ikin_sqrt #(
   parameter int VAL_W  = 48,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [VAL_W-1:0]    in_value,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [VAL_W/2-1:0]  out_root,
   output logic [SIDE_W-1:0]   out_side
);
   localparam int STEPS = VAL_W / 2;

   wire [VAL_W-1:0]  val_w  [0:STEPS];
   wire [VAL_W-1:0]  root_w [0:STEPS];
   wire [SIDE_W-1:0] side_w [0:STEPS];
   wire              vld_w  [0:STEPS];

   assign val_w[0]  = in_value;
   assign root_w[0] = '0;
   assign side_w[0] = in_side;
   assign vld_w[0]  = in_valid;

   for (genvar k = 0; k < STEPS; k++) begin : g_cell
      localparam logic [VAL_W-1:0] BIT = {{(VAL_W-1){1'b0}}, 1'b1} << (VAL_W - 2 - 2 * k);
      logic [VAL_W-1:0]  val_ff, val_in, root_ff, root_in;
      logic [SIDE_W-1:0] side_ff;
      logic              vld_ff;
      logic [VAL_W:0]    trial;

      always_comb begin
         trial = {1'b0, root_w[k]} + {1'b0, BIT};
         if ({1'b0, val_w[k]} >= trial) begin
            val_in  = val_w[k] - trial[VAL_W-1:0];
            root_in = (root_w[k] >> 1) + BIT;
         end else begin
            val_in  = val_w[k];
            root_in = root_w[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_w[k];
         end
         if (en) begin
            val_ff  <= val_in;
            root_ff <= root_in;
            side_ff <= side_w[k];
         end
      end

      assign val_w[k+1]  = val_ff;
      assign root_w[k+1] = root_ff;
      assign side_w[k+1] = side_ff;
      assign vld_w[k+1]  = vld_ff;
   end

   assign out_valid = vld_w[STEPS];
   assign out_root  = root_w[STEPS][VAL_W/2-1:0];
   assign out_side  = side_w[STEPS];

endmodule

// ----- design/ikin_div.sv -----
// ----------------------------------------------------------------------------
// ikin_div: pipelined fractional divider
// Restoring division, one quotient bit per cell, giving num / den in Q.30.
// A ratio of one or more returns exactly 1.0.
// ----------------------------------------------------------------------------
module ikin_div #(
   parameter int DIV_W  = 34,
   parameter int SIDE_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [DIV_W-1:0]            in_num,
   input  logic [DIV_W-1:0]            in_den,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [ikin_pkg::Q30_W-1:0]  out_quot,
   output logic [SIDE_W-1:0]           out_side
);
   import ikin_pkg::*;

   localparam int STEPS = Q30_W;

   wire [DIV_W-1:0]  rem_w  [0:STEPS];
   wire [DIV_W-1:0]  den_w  [0:STEPS];
   wire [Q30_W-1:0]  quot_w [0:STEPS];
   wire [SIDE_W-1:0] side_w [0:STEPS];
   wire              sat_w  [0:STEPS];
   wire              vld_w  [0:STEPS];

   assign rem_w[0]  = in_num;
   assign den_w[0]  = in_den;
   assign quot_w[0] = '0;
   assign side_w[0] = in_side;
   assign sat_w[0]  = in_num >= in_den;
   assign vld_w[0]  = in_valid;

   for (genvar k = 0; k < STEPS; k++) begin : g_cell
      logic [DIV_W-1:0]  rem_ff, rem_in, den_ff, diff;
      logic [Q30_W-1:0]  quot_ff, quot_in;
      logic [SIDE_W-1:0] side_ff;
      logic              sat_ff, vld_ff, take;

      always_comb begin
         take    = rem_w[k] >= den_w[k];
         diff    = take ? rem_w[k] - den_w[k] : rem_w[k];
         rem_in  = {diff[DIV_W-2:0], 1'b0};
         quot_in = {quot_w[k][Q30_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_w[k];
         end
         if (en) begin
            rem_ff  <= rem_in;
            den_ff  <= den_w[k];
            quot_ff <= quot_in;
            side_ff <= side_w[k];
            sat_ff  <= sat_w[k];
         end
      end

      assign rem_w[k+1]  = rem_ff;
      assign den_w[k+1]  = den_ff;
      assign quot_w[k+1] = quot_ff;
      assign side_w[k+1] = side_ff;
      assign sat_w[k+1]  = sat_ff;
      assign vld_w[k+1]  = vld_ff;
   end

   assign out_valid = vld_w[STEPS];
   assign out_quot  = sat_w[STEPS] ? Q30_ONE : quot_w[STEPS];
   assign out_side  = side_w[STEPS];

endmodule

// ----- design/ikin_cordic.sv -----
// ----------------------------------------------------------------------------
// ikin_cordic: pipelined vectoring CORDIC
// Angle of a first-quadrant vector in Q.30 radians, one rotation per cell.
// Zero y gives 0 and zero x gives pi/2.
// ----------------------------------------------------------------------------
module ikin_cordic #(
   parameter int STAGES = 16,
   parameter int SIDE_W = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [ikin_pkg::Q30_W-1:0]        in_y,
   input  logic [ikin_pkg::Q30_W-1:0]        in_x,
   input  logic [SIDE_W-1:0]                 in_side,
   output logic                              out_valid,
   output logic signed [ikin_pkg::Z_W-1:0]   out_angle,
   output logic [SIDE_W-1:0]                 out_side
);
   import ikin_pkg::*;

   wire signed [XY_W-1:0] x_w    [0:STAGES];
   wire signed [XY_W-1:0] y_w    [0:STAGES];
   wire signed [Z_W-1:0]  z_w    [0:STAGES];
   wire [SIDE_W-1:0]      side_w [0:STAGES];
   wire                   yz_w   [0:STAGES];
   wire                   xz_w   [0:STAGES];
   wire                   vld_w  [0:STAGES];

   assign x_w[0]    = XY_W'(in_x);
   assign y_w[0]    = XY_W'(in_y);
   assign z_w[0]    = '0;
   assign side_w[0] = in_side;
   assign yz_w[0]   = in_y == '0;
   assign xz_w[0]   = in_x == '0;
   assign vld_w[0]  = in_valid;

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_q30(i));
      logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in, dx, dy;
      logic signed [Z_W-1:0]  z_ff, z_in;
      logic [SIDE_W-1:0]      side_ff;
      logic                   yz_ff, xz_ff, vld_ff;

      always_comb begin
         dx = x_w[i] >>> i;
         dy = y_w[i] >>> i;
         if (!y_w[i][XY_W-1]) begin
            x_in = x_w[i] + dy;
            y_in = y_w[i] - dx;
            z_in = z_w[i] + ATAN;
         end else begin
            x_in = x_w[i] - dy;
            y_in = y_w[i] + dx;
            z_in = z_w[i] - ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_w[i];
         end
         if (en) begin
            x_ff    <= x_in;
            y_ff    <= y_in;
            z_ff    <= z_in;
            side_ff <= side_w[i];
            yz_ff   <= yz_w[i];
            xz_ff   <= xz_w[i];
         end
      end

      assign x_w[i+1]    = x_ff;
      assign y_w[i+1]    = y_ff;
      assign z_w[i+1]    = z_ff;
      assign side_w[i+1] = side_ff;
      assign yz_w[i+1]   = yz_ff;
      assign xz_w[i+1]   = xz_ff;
      assign vld_w[i+1]  = vld_ff;
   end

   assign out_valid = vld_w[STAGES];
   assign out_side  = side_w[STAGES];
   assign out_angle = yz_w[STAGES] ? '0 :
                      xz_w[STAGES] ? $signed(HALF_PI_Q30) : z_w[STAGES];

endmodule

// ----- design/two_link_inverse_kinematics_core.sv -----
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics_core: two-link planar arm solver
// Law-of-cosines inverse kinematics built from chains of root, divide and
// CORDIC cells.
//
// req_ beats carry a target point: tdata = {y_pos, x_pos}, Q8.8 signed.
// rsp_ beats carry the joint angles: tdata = {elbow_angle, shoulder_angle},
// Q3.13 radians; tuser = solvable. Unreachable targets, a target at the
// origin and a zero link length return zero angles with solvable low.
// csr_ writes set upper_len (index 0) and lower_len (index 1), Q8.8.
// Throughput: one beat per cycle while rsp_tready does not hold the chain.
// A beat passes through the distance root, the divide cells, the angle
// roots, the CORDIC_STAGES arc cells and 9 further register stages.
// Reset clears every valid flag and loads both links with 2022.
// One enable drives the whole chain: while a result waits on rsp_tready,
// the chain holds and req_tready is low; a waiting beat is never dropped.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics_core #(
   parameter int ANGLE_WIDTH   = ikin_pkg::ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = ikin_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ikin_pkg::IN_DATA_W-1:0]       req_tdata,   // x_pos, y_pos
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((2*ANGLE_WIDTH+7)/8)*8-1:0]   rsp_tdata,   // shoulder_angle, elbow_angle
   output logic                                 rsp_tuser,   // solvable
   input  logic                                 csr_we,
   input  logic [ikin_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [ikin_pkg::LEN_W-1:0]           csr_wdata
);
   import ikin_pkg::*;

   localparam int OUT_DATA_W = ((2 * ANGLE_WIDTH + 7) / 8) * 8;
   localparam int RND_SH     = 33 - ANGLE_WIDTH;
   localparam logic signed [ANG_W:0] RND_HALF = {{ANG_W{1'b0}}, 1'b1} << (RND_SH - 1);
   localparam logic signed [ANG_W:0] ANG_HI =
      ({{ANG_W{1'b0}}, 1'b1} << (ANGLE_WIDTH - 1)) - 1;
   localparam logic signed [ANG_W:0] ANG_LO = -ANG_HI - 1;
   localparam logic signed [ANG_W-1:0] PI_ANG = ANG_W'(PI_Q30);
   localparam logic [TRIG_W-1:0] TRIG_ONE = {{(TRIG_W-1){1'b0}}, 1'b1} << 60;

   function automatic logic [ANGLE_WIDTH-1:0] to_angle(input logic signed [ANG_W-1:0] v);
      logic signed [ANG_W:0] sum, r;
      sum = {v[ANG_W-1], v} + RND_HALF;
      r   = sum >>> RND_SH;
      if (r > ANG_HI) begin
         r = ANG_HI;
      end else if (r < ANG_LO) begin
         r = ANG_LO;
      end
      return r[ANGLE_WIDTH-1:0];
   endfunction

   logic pipe_en;

   // link registers and their products
   logic [LEN_W-1:0] l1_ff, l2_ff;
   logic [LP_W-1:0]  l1s_ff, l2s_ff, l12_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_ff <= LEN_RESET;
         l2_ff <= LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_UPPER_LEN: l1_ff <= csr_wdata;
            REG_LOWER_LEN: l2_ff <= csr_wdata;
         endcase
      end
      l1s_ff <= LP_W'(l1_ff) * LP_W'(l1_ff);
      l2s_ff <= LP_W'(l2_ff) * LP_W'(l2_ff);
      l12_ff <= LP_W'(l1_ff) * LP_W'(l2_ff);
   end

   // stage A: magnitudes and squares
   logic [COORD_WIDTH-1:0] x_raw, y_raw;
   logic [MAG_W-1:0]       ax_in, ay_in, ay_a_ff;
   logic [SQ_W-1:0]        ax2_in, ay2_in, ax2_a_ff, ay2_a_ff;
   logic                   yneg_a_ff, vld_a_ff;

   always_comb begin
      x_raw  = req_tdata[COORD_WIDTH-1:0];
      y_raw  = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
      ax_in  = x_raw[COORD_WIDTH-1] ? ~x_raw + 1'b1 : x_raw;
      ay_in  = y_raw[COORD_WIDTH-1] ? ~y_raw + 1'b1 : y_raw;
      ax2_in = SQ_W'(ax_in) * SQ_W'(ax_in);
      ay2_in = SQ_W'(ay_in) * SQ_W'(ay_in);
   end

   // stage B: squared distance
   root_side_type side_b_ff;
   logic          vld_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else if (pipe_en) begin
         vld_a_ff <= req_tvalid;
         vld_b_ff <= vld_a_ff;
      end
      if (pipe_en) begin
         ax2_a_ff       <= ax2_in;
         ay2_a_ff       <= ay2_in;
         ay_a_ff        <= ay_in;
         yneg_a_ff      <= y_raw[COORD_WIDTH-1];
         side_b_ff.l3s  <= ax2_a_ff + ay2_a_ff;
         side_b_ff.ay   <= ay_a_ff;
         side_b_ff.yneg <= yneg_a_ff;
      end
   end

   // distance root
   logic                 vld_r;
   logic [L3_W-1:0]      l3_r;
   logic [$bits(root_side_type)-1:0] side_r_vec;
   root_side_type        side_r;

   ikin_sqrt #(.VAL_W(ROOT_IN_W), .SIDE_W($bits(root_side_type))) u_dist_root (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (vld_b_ff),
      .in_value  ({side_b_ff.l3s, {(ROOT_IN_W-SQ_W){1'b0}}}),
      .in_side   (side_b_ff),
      .out_valid (vld_r),
      .out_root  (l3_r),
      .out_side  (side_r_vec)
   );

   assign side_r = root_side_type'(side_r_vec);

   // stage C1: cosine-a numerator and denominator product
   logic [SUM_W-1:0]    pos_a_in, mag_a_in, mag_a_c1_ff, l3s_c1_ff;
   logic                aneg_in, aneg_c1_ff, zero_in, zero_c1_ff, yneg_c1_ff, vld_c1_ff;
   logic [PROD_A_W-1:0] prod_a_in, prod_a_c1_ff;
   logic [L3_W-1:0]     l3_c1_ff;
   logic [MAG_W-1:0]    ay_c1_ff;

   always_comb begin
      pos_a_in  = SUM_W'(side_r.l3s) + SUM_W'(l2s_ff);
      aneg_in   = pos_a_in < SUM_W'(l1s_ff);
      mag_a_in  = aneg_in ? SUM_W'(l1s_ff) - pos_a_in : pos_a_in - SUM_W'(l1s_ff);
      prod_a_in = PROD_A_W'(l3_r) * PROD_A_W'(l2_ff);
      zero_in   = (side_r.l3s == '0) || (l1_ff == '0) || (l2_ff == '0);
   end

   // stage C2: divider operands and reach check
   logic [DIV_A_W-2:0] num_a_in, den_a_in;
   logic [SUM_W-1:0]   pos_c_in, mag_c_in;
   logic               bneg_in, bad_in;
   logic [DIV_A_W-1:0] num_a_c2_ff, den_a_c2_ff;
   logic [DIV_B_W-1:0] num_b_c2_ff, den_b_c2_ff;
   logic [DIV_C_W-1:0] num_c_c2_ff, den_c_c2_ff;
   logic               aneg_c2_ff, yneg_c2_ff, bneg_c2_ff, bad_c2_ff, vld_c2_ff;

   always_comb begin
      num_a_in = {mag_a_c1_ff, 8'b0};
      den_a_in = {prod_a_c1_ff, 1'b0};
      bad_in   = zero_c1_ff || (num_a_in > den_a_in);
      pos_c_in = SUM_W'(l1s_ff) + SUM_W'(l2s_ff);
      bneg_in  = pos_c_in < l3s_c1_ff;
      mag_c_in = bneg_in ? l3s_c1_ff - pos_c_in : pos_c_in - l3s_c1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_c1_ff <= 1'b0;
         vld_c2_ff <= 1'b0;
      end else if (pipe_en) begin
         vld_c1_ff <= vld_r;
         vld_c2_ff <= vld_c1_ff;
      end
      if (pipe_en) begin
         mag_a_c1_ff  <= mag_a_in;
         aneg_c1_ff   <= aneg_in;
         prod_a_c1_ff <= prod_a_in;
         zero_c1_ff   <= zero_in;
         l3s_c1_ff    <= SUM_W'(side_r.l3s);
         l3_c1_ff     <= l3_r;
         ay_c1_ff     <= side_r.ay;
         yneg_c1_ff   <= side_r.yneg;
         num_a_c2_ff  <= DIV_A_W'(num_a_in);
         den_a_c2_ff  <= DIV_A_W'(den_a_in);
         num_b_c2_ff  <= DIV_B_W'({ay_c1_ff, 8'b0});
         den_b_c2_ff  <= DIV_B_W'(l3_c1_ff);
         num_c_c2_ff  <= DIV_C_W'(mag_c_in);
         den_c_c2_ff  <= DIV_C_W'({l12_ff, 1'b0});
         aneg_c2_ff   <= aneg_c1_ff;
         yneg_c2_ff   <= yneg_c1_ff;
         bneg_c2_ff   <= bneg_in;
         bad_c2_ff    <= bad_in;
      end
   end

   // cosine a, sine theta, cosine b
   logic [Q30_W-1:0] ca_d, sn_d, cb_d;
   logic             aneg_d, yneg_d, vld_d;
   logic [1:0]       flags_d;

   ikin_div #(.DIV_W(DIV_A_W), .SIDE_W(1)) u_div_a (
      .clock (clock), .reset (reset), .en (pipe_en),
      .in_valid (vld_c2_ff), .in_num (num_a_c2_ff), .in_den (den_a_c2_ff),
      .in_side (aneg_c2_ff),
      .out_valid (), .out_quot (ca_d), .out_side (aneg_d)
   );

   ikin_div #(.DIV_W(DIV_B_W), .SIDE_W(1)) u_div_s (
      .clock (clock), .reset (reset), .en (pipe_en),
      .in_valid (vld_c2_ff), .in_num (num_b_c2_ff), .in_den (den_b_c2_ff),
      .in_side (yneg_c2_ff),
      .out_valid (), .out_quot (sn_d), .out_side (yneg_d)
   );

   ikin_div #(.DIV_W(DIV_C_W), .SIDE_W(2)) u_div_b (
      .clock (clock), .reset (reset), .en (pipe_en),
      .in_valid (vld_c2_ff), .in_num (num_c_c2_ff), .in_den (den_c_c2_ff),
      .in_side ({bad_c2_ff, bneg_c2_ff}),
      .out_valid (vld_d), .out_quot (cb_d), .out_side (flags_d)
   );

   // stage T: one minus square for the complementary roots
   logic [TRIG_W-1:0] s2_a_ff, s2_s_ff, s2_b_ff;
   logic [Q30_W-1:0]  ca_t_ff, sn_t_ff, cb_t_ff;
   logic              aneg_t_ff, yneg_t_ff, vld_t_ff;
   logic [1:0]        flags_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_t_ff <= 1'b0;
      end else if (pipe_en) begin
         vld_t_ff <= vld_d;
      end
      if (pipe_en) begin
         s2_a_ff    <= TRIG_ONE - TRIG_W'(ca_d) * TRIG_W'(ca_d);
         s2_s_ff    <= TRIG_ONE - TRIG_W'(sn_d) * TRIG_W'(sn_d);
         s2_b_ff    <= TRIG_ONE - TRIG_W'(cb_d) * TRIG_W'(cb_d);
         ca_t_ff    <= ca_d;
         sn_t_ff    <= sn_d;
         cb_t_ff    <= cb_d;
         aneg_t_ff  <= aneg_d;
         yneg_t_ff  <= yneg_d;
         flags_t_ff <= flags_d;
      end
   end

   logic [Q30_W-1:0] root_a, root_s, root_b, ca_q, sn_q, cb_q;
   logic             aneg_q, yneg_q, vld_q;
   logic [1:0]       flags_q;

   ikin_sqrt #(.VAL_W(TRIG_W), .SIDE_W(Q30_W + 1)) u_root_a (
      .clock (clock), .reset (reset), .en (pipe_en),
      .in_valid (vld_t_ff), .in_value (s2_a_ff), .in_side ({aneg_t_ff, ca_t_ff}),
      .out_valid (), .out_root (root_a), .out_side ({aneg_q, ca_q})
   );

   ikin_sqrt #(.VAL_W(TRIG_W), .SIDE_W(Q30_W + 1)) u_root_s (
      .clock (clock), .reset (reset), .en (pipe_en),
      .in_valid (vld_t_ff), .in_value (s2_s_ff), .in_side ({yneg_t_ff, sn_t_ff}),
      .out_valid (), .out_root (root_s), .out_side ({yneg_q, sn_q})
   );

   ikin_sqrt #(.VAL_W(TRIG_W), .SIDE_W(Q30_W + 2)) u_root_b (
      .clock (clock), .reset (reset), .en (pipe_en),
      .in_valid (vld_t_ff), .in_value (s2_b_ff), .in_side ({flags_t_ff, cb_t_ff}),
      .out_valid (vld_q), .out_root (root_b), .out_side ({flags_q, cb_q})
   );

   // arc angles
   logic signed [Z_W-1:0] z_a, z_s, z_b;
   logic                  aneg_z, yneg_z, vld_z;
   logic [1:0]            flags_z;

   ikin_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_arc_a (
      .clock (clock), .reset (reset), .en (pipe_en),
      .in_valid (vld_q), .in_y (root_a), .in_x (ca_q), .in_side (aneg_q),
      .out_valid (), .out_angle (z_a), .out_side (aneg_z)
   );

   ikin_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_arc_s (
      .clock (clock), .reset (reset), .en (pipe_en),
      .in_valid (vld_q), .in_y (sn_q), .in_x (root_s), .in_side (yneg_q),
      .out_valid (), .out_angle (z_s), .out_side (yneg_z)
   );

   ikin_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(2)) u_arc_b (
      .clock (clock), .reset (reset), .en (pipe_en),
      .in_valid (vld_q), .in_y (root_b), .in_x (cb_q), .in_side (flags_q),
      .out_valid (vld_z), .out_angle (z_b), .out_side (flags_z)
   );

   // angle sums and rounding
   logic signed [ANG_W-1:0] za_ext, zs_ext, zb_ext;
   logic signed [ANG_W-1:0] aca_f1_ff, ass_f1_ff, acb_f1_ff, alpha_f2_ff, acb_f2_ff;
   logic signed [ANG_W-1:0] alpha_f3_ff, beta_f3_ff;
   logic                    bad_f1_ff, bad_f2_ff, bad_f3_ff;
   logic                    vld_f1_ff, vld_f2_ff, vld_f3_ff;
   logic                    rsp_tvalid_ff, rsp_tuser_ff;
   logic [OUT_DATA_W-1:0]   rsp_tdata_ff;

   always_comb begin
      za_ext = ANG_W'(z_a);
      zs_ext = ANG_W'(z_s);
      zb_ext = ANG_W'(z_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_f1_ff     <= 1'b0;
         vld_f2_ff     <= 1'b0;
         vld_f3_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (pipe_en) begin
         vld_f1_ff     <= vld_z;
         vld_f2_ff     <= vld_f1_ff;
         vld_f3_ff     <= vld_f2_ff;
         rsp_tvalid_ff <= vld_f3_ff;
      end
      if (pipe_en) begin
         aca_f1_ff   <= aneg_z ? PI_ANG - za_ext : za_ext;
         ass_f1_ff   <= yneg_z ? -zs_ext : zs_ext;
         acb_f1_ff   <= flags_z[0] ? PI_ANG - zb_ext : zb_ext;
         bad_f1_ff   <= flags_z[1];
         alpha_f2_ff <= PI_ANG - aca_f1_ff - ass_f1_ff;
         acb_f2_ff   <= acb_f1_ff;
         bad_f2_ff   <= bad_f1_ff;
         alpha_f3_ff <= alpha_f2_ff;
         beta_f3_ff  <= alpha_f2_ff - acb_f2_ff;
         bad_f3_ff   <= bad_f2_ff;
         rsp_tuser_ff <= !bad_f3_ff;
         if (bad_f3_ff) begin
            rsp_tdata_ff <= '0;
         end else begin
            rsp_tdata_ff <= OUT_DATA_W'({to_angle(beta_f3_ff), to_angle(alpha_f3_ff)});
         end
      end
   end

   assign pipe_en    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = pipe_en;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_unsolved_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("unsolvable beat carries nonzero angles");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

endmodule
